>>> rtl/core/psl_pkg.sv
`default_nettype none
package psl_pkg;

   localparam int CAPACITY   = 256;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 9;
   localparam int COUNT_W    = 9;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int GROUP      = 16;
   localparam int GSEL_W     = $clog2(GROUP);
   localparam int NUM_GROUPS = CAPACITY / GROUP;
   localparam int GHI_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int REQ_W      = 48;
   localparam int RSP_W      = 48;

   typedef logic [DATA_W-1:0] word_type;

   typedef enum logic [KIND_W-1:0] {
      K_INSERT = 3'd0,
      K_REMOVE = 3'd1,
      K_READ   = 3'd2,
      K_WRITE  = 3'd3,
      K_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic             shift_up;
      logic             shift_down;
      logic             load;
      logic [POS_W-1:0] position;
      word_type         value;
   } cell_cmd_type;

endpackage
`default_nettype wire

>>> rtl/core/psl_cell.sv
`default_nettype none
module psl_cell
   import psl_pkg::*;
(
   input  wire logic             clock,
   input  wire cell_cmd_type     cmd,
   input  wire logic [POS_W-1:0] index,
   input  wire word_type         from_below,
   input  wire word_type         from_above,
   output word_type              entry
);

   word_type entry_ff;
   word_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.shift_up && (index > cmd.position)) begin
         entry_in = from_below;
      end else if ((cmd.shift_up || cmd.load) && (index == cmd.position)) begin
         entry_in = cmd.value;
      end else if (cmd.shift_down && (index >= cmd.position)) begin
         entry_in = from_above;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

>>> rtl/core/psl_read_tree.sv
`default_nettype none
module psl_read_tree
   import psl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire word_type          entries [CAPACITY],
   input  wire logic [GSEL_W-1:0] position,
   input  wire logic [GHI_W-1:0]  group_sel,
   output word_type               read_word
);

   word_type partial_ff [NUM_GROUPS];

   // first level: pick one word inside each group of cells, register it;
   // hold it while the request waits in execute
   always_ff @(posedge clock) begin
      if (load) begin
         for (int g = 0; g < NUM_GROUPS; g++) begin
            partial_ff[g] <= entries[{GHI_W'(g), position}];
         end
      end
   end

   // second level: pick the group
   assign read_word = partial_ff[group_sel];

endmodule
`default_nettype wire

>>> rtl/core/positional_list_store_unit.sv
`default_nettype none
// Positional list store: a bounded list of up to 256 32-bit words addressed by
// position, counting from 0. Each request on the req_ channel inserts,
// removes, reads, overwrites or clears; each request yields exactly one
// response on the rsp_ channel with the read word, status, item count and an
// empty flag.
// Channels: req_tdata = {pad, value, position, kind}, rsp_tdata = {pad,
// is_empty, item_count, status, read_value}; both use tvalid/tready.
// Storage is a chain of cells, one word each; an insert or remove shifts all
// cells above the position in the same cycle as the request is taken.
// The response is registered: the request is decoded when taken, and the
// response register loads at the end of the execute step that follows.
// A new request is taken only in the idle state, so the block cannot take
// one while the last request is still in the execute step.
// The response register decouples the sides: a new request is taken while a
// response still waits; if the receiver stalls, the following request holds
// in the execute step until the response register frees up.
// Reset (synchronous, active high) empties the list and drops any pending
// response; cell contents are not cleared and are never visible unwritten.
module positional_list_store_unit
   import psl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // [2:0] kind, [11:3] position, [43:12] value, [47:44] zero
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [31:0] read_value, [33:32] status, [42:34] item_count, [43] is_empty,
   // [47:44] zero
   output logic [RSP_W-1:0]      rsp_tdata
);

   // unpack request fields
   logic [KIND_W-1:0] req_kind;
   logic [POS_W-1:0]  req_position;
   word_type          req_value;

   assign req_kind     = req_tdata[KIND_W-1:0];
   assign req_position = req_tdata[KIND_W +: POS_W];
   assign req_value    = req_tdata[KIND_W + POS_W +: DATA_W];

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      load_rsp;

   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   status_type          status_ff;
   status_type          status_in;
   logic                read_ok_ff;
   logic                read_ok_in;
   logic [GHI_W-1:0]    group_ff;
   cell_cmd_type        cmd;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff;
   logic [RSP_W-1:0]    rsp_data_in;

   word_type            entries [CAPACITY];
   word_type            read_word;

   assign accept = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         S_IDLE: req_tready = 1'b1;
         S_EXEC: load_rsp   = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
            load_rsp   = 1'b0;
         end
      endcase
   end

   // decode the request: range/full checks, new count, cell command
   always_comb begin
      count_in       = count_ff;
      status_in      = status_ff;
      read_ok_in     = read_ok_ff;
      cmd            = '0;
      cmd.position   = req_position;
      cmd.value      = req_value;
      if (accept) begin
         status_in  = ST_OK;
         read_ok_in = 1'b0;
         unique case (req_kind)
            K_INSERT: begin
               if (req_position > count_ff) begin
                  status_in = ST_RANGE;
               end else if (count_ff == COUNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.shift_up = 1'b1;
                  count_in     = count_ff + COUNT_W'(1);
               end
            end
            K_REMOVE: begin
               if (req_position >= count_ff) begin
                  status_in = ST_RANGE;
               end else begin
                  cmd.shift_down = 1'b1;
                  count_in       = count_ff - COUNT_W'(1);
               end
            end
            K_READ: begin
               if (req_position >= count_ff) status_in  = ST_RANGE;
               else                          read_ok_in = 1'b1;
            end
            K_WRITE: begin
               if (req_position >= count_ff) status_in = ST_RANGE;
               else                          cmd.load  = 1'b1;
            end
            K_CLEAR: count_in = '0;
            default: status_in = ST_OK;  // unused kinds: no effect
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the decoded outcome for the execute step
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      read_ok_ff <= read_ok_in;
      if (accept) group_ff <= req_position[IDX_W-1 -: GHI_W];
      rsp_data_ff <= rsp_data_in;
   end

   // cell chain: each cell sees its lower and upper neighbor
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      word_type below;
      word_type above;
      if (i == 0) begin : g_bottom
         assign below = req_value;
      end else begin : g_mid_lo
         assign below = entries[i-1];
      end
      if (i == CAPACITY - 1) begin : g_top
         assign above = entries[i];
      end else begin : g_mid_hi
         assign above = entries[i+1];
      end
      psl_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (POS_W'(i)),
         .from_below (below),
         .from_above (above),
         .entry      (entries[i])
      );
   end

   // registered two-level read select; first level captures at accept
   psl_read_tree u_read_tree (
      .clock     (clock),
      .load      (accept),
      .entries   (entries),
      .position  (req_position[GSEL_W-1:0]),
      .group_sel (group_ff),
      .read_word (read_word)
   );

   // response register: load at end of execute, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[DATA_W-1:0]                     = read_ok_ff ? read_word : '0;
         rsp_data_in[DATA_W +: STATUS_W]             = status_ff;
         rsp_data_in[DATA_W + STATUS_W +: COUNT_W]   = count_ff;
         rsp_data_in[DATA_W + STATUS_W + COUNT_W]    = (count_ff == '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

>>> bench/positional_list_store_unit_tb.sv
`timescale 1ns / 100ps
module positional_list_store_unit_tb;
   import psl_pkg::*;

   // Response field offsets inside rsp_tdata, lowest field first.
   localparam int RSP_STATUS_LSB = DATA_W;
   localparam int RSP_COUNT_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_EMPTY_BIT  = RSP_COUNT_LSB + COUNT_W;
   localparam int REQ_PAD_W      = REQ_W - KIND_W - POS_W - DATA_W;

   // Kind codes the block does not decode; they must leave the list alone.
   localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

   localparam int MAX_REPORTS = 10;
   localparam int CYCLE_LIMIT = 800000;
   localparam int TAIL_CYCLES = 20;
   localparam int SEGMENTS    = 12;
   localparam int SEGMENT_LEN = 100;

   typedef struct packed {
      word_type             read_value;
      status_type           status;
      logic [COUNT_W-1:0]   item_count;
      logic                 is_empty;
   } list_outcome_t;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   // [2:0] kind, [11:3] position, [43:12] value, [47:44] zero
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   // [31:0] read_value, [33:32] status, [42:34] item_count, [43] is_empty,
   // [47:44] zero
   logic [RSP_W-1:0]   rsp_tdata;

   // Shadow copy of the list, advanced at the moment each request is taken.
   word_type           shadow_words [CAPACITY];
   int                 shadow_count;
   list_outcome_t      outcomes_due [$];

   int                 failures;
   int                 cycles;
   // When set, the matching side runs without any idle cycles.
   bit                 send_steady;
   bit                 accept_steady;

   positional_list_store_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a response.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 40);
   endfunction

   // Position inside [0, limit) most of the time, leaning on both ends;
   // otherwise anywhere from limit up to the top of the 9-bit field.
   function automatic logic [POS_W-1:0] pick_position(int limit);
      int r;
      r = $urandom_range(0, 99);
      if (limit > 0 && r < 90) begin
         if (r < 10)
            return '0;
         else if (r < 20)
            return POS_W'(limit - 1);
         else
            return POS_W'($urandom_range(0, limit - 1));
      end
      return POS_W'($urandom_range(limit, (1 << POS_W) - 1));
   endfunction

   function automatic word_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      else if (r < 16)
         return '1;
      else
         return word_type'($urandom);
   endfunction

   // Apply one request to the shadow list and return the response it must
   // produce. Range is checked before fullness on insert.
   function automatic list_outcome_t list_op_outcome(logic [KIND_W-1:0] kind,
                                                      logic [POS_W-1:0] position,
                                                      word_type value);
      list_outcome_t res;
      int            pos;
      pos = int'(position);
      res.read_value = '0;
      res.status     = ST_OK;
      case (kind)
         K_INSERT: begin
            if (pos > shadow_count)
               res.status = ST_RANGE;
            else if (shadow_count >= CAPACITY)
               res.status = ST_FULL;
            else begin
               for (int i = shadow_count; i > pos; i--)
                  shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = value;
               shadow_count++;
            end
         end
         K_REMOVE: begin
            if (pos >= shadow_count)
               res.status = ST_RANGE;
            else begin
               for (int i = pos; i + 1 < shadow_count; i++)
                  shadow_words[i] = shadow_words[i+1];
               shadow_count--;
            end
         end
         K_READ: begin
            if (pos >= shadow_count)
               res.status = ST_RANGE;
            else
               res.read_value = shadow_words[pos];
         end
         K_WRITE: begin
            if (pos >= shadow_count)
               res.status = ST_RANGE;
            else
               shadow_words[pos] = value;
         end
         K_CLEAR: shadow_count = 0;
         default: ;
      endcase
      res.item_count = COUNT_W'(shadow_count);
      res.is_empty   = (shadow_count == 0);
      return res;
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         if (failures < MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
         failures++;
      end
   endfunction

   // Present one request, hold it until taken, then predict its response.
   // With a zero gap, valid stays high into the next request.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [POS_W-1:0] position,
                               input word_type value);
      int gap;
      gap = send_steady ? 0 : pick_gap();
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, value, position, kind};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      outcomes_due.push_back(list_op_outcome(kind, position, value));
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         // scramble the bus while idle; the block must not look at it
         req_tdata  <= REQ_W'({$urandom, $urandom});
         repeat (gap - 1)
            @(negedge clock);
      end
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
   endtask

   // One random request. Insert and remove odds are given; the rest is split
   // among reads, writes, the occasional clear, unused kinds and pure noise.
   task automatic send_random_op(int insert_pct, int remove_pct, bit allow_clear);
      int r;
      int s;
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < insert_pct)
         send_request(K_INSERT, pick_position(shadow_count + 1), pick_value());
      else if (r < insert_pct + remove_pct)
         send_request(K_REMOVE, pick_position(shadow_count), pick_value());
      else if (s < 50)
         send_request(K_READ, pick_position(shadow_count), pick_value());
      else if (s < 85)
         send_request(K_WRITE, pick_position(shadow_count), pick_value());
      else if (s < 89 && allow_clear)
         send_request(K_CLEAR, POS_W'($urandom), pick_value());
      else if (s < 93)
         send_request(KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                      POS_W'($urandom), pick_value());
      else
         send_request(KIND_W'($urandom), POS_W'($urandom), pick_value());
   endtask

   // Empty-list rejects, inserts at front, middle and end, reads and writes
   // including the first position past the end, removes at every end,
   // far out-of-range positions, unused kinds and clear.
   task automatic test_directed_cases();
      send_steady   = 1'b0;
      accept_steady = 1'b0;
      // nothing stored yet: every positional access is out of range
      send_request(K_READ, '0, pick_value());
      send_request(K_REMOVE, '0, pick_value());
      send_request(K_WRITE, '0, pick_value());
      send_request(K_INSERT, POS_W'(1), pick_value());
      // build four entries: first, append, prepend, middle
      send_request(K_INSERT, '0, '0);
      send_request(K_INSERT, POS_W'(1), '1);
      send_request(K_INSERT, '0, word_type'($urandom));
      send_request(K_INSERT, POS_W'(2), word_type'($urandom));
      send_request(K_WRITE, POS_W'(2), '1);
      send_request(K_WRITE, POS_W'(4), '0);
      for (int i = 0; i <= 4; i++)
         send_request(K_READ, POS_W'(i), pick_value());
      // remove from the middle, the top, then the bottom
      send_request(K_REMOVE, POS_W'(1), pick_value());
      send_request(K_REMOVE, POS_W'(2), pick_value());
      send_request(K_REMOVE, '0, pick_value());
      send_request(K_READ, '1, pick_value());
      send_request(K_INSERT, '1, pick_value());
      for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
         send_request(KIND_W'(k), POS_W'($urandom), pick_value());
      send_request(K_CLEAR, POS_W'($urandom), pick_value());
      send_request(K_READ, '0, pick_value());
   endtask

   // Grow the list to capacity with random inserts, probe the full and range
   // rejects at the top, then churn near the limit.
   task automatic test_fill_to_capacity();
      send_steady   = 1'b1;
      accept_steady = 1'b0;
      while (shadow_count < CAPACITY) begin
         if (shadow_count == CAPACITY / 2)
            send_steady = 1'b0;
         send_request(K_INSERT, pick_position(shadow_count + 1), pick_value());
      end
      accept_steady = 1'b1;
      send_request(K_INSERT, '0, pick_value());
      send_request(K_INSERT, POS_W'(CAPACITY), pick_value());
      send_request(K_INSERT, POS_W'(CAPACITY + 1), pick_value());
      send_request(K_READ, POS_W'(CAPACITY - 1), pick_value());
      send_request(K_READ, POS_W'(CAPACITY), pick_value());
      send_request(K_WRITE, POS_W'(CAPACITY - 1), '1);
      send_request(K_REMOVE, POS_W'(CAPACITY - 1), pick_value());
      send_request(K_INSERT, POS_W'(CAPACITY - 1), pick_value());
      send_request(K_REMOVE, '0, pick_value());
      send_request(K_INSERT, '0, pick_value());
      accept_steady = 1'b0;
      repeat (40)
         send_random_op(40, 35, 1'b0);
   endtask

   // Segments that grow, hold and shrink the list, with idling switched
   // off on one side or on both sides in some of them.
   task automatic test_random_mix();
      int insert_pct;
      int remove_pct;
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg % 4 < 2) begin
            insert_pct = 65;
            remove_pct = 10;
         end else if (seg % 4 == 2) begin
            insert_pct = 35;
            remove_pct = 30;
         end else begin
            insert_pct = 10;
            remove_pct = 60;
         end
         send_steady   = (seg % 3 == 1);
         accept_steady = (seg % 5 == 2);
         repeat (SEGMENT_LEN)
            send_random_op(insert_pct, remove_pct, seg % 4 == 2);
      end
   endtask

   // Receiver: stall for random stretches unless told to run steady.
   initial begin : drive_rsp_ready
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!accept_steady && $urandom_range(0, 99) < 30)
               stall_left = pick_gap();
         end
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin : check_responses
      list_outcome_t due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcomes_due.size() == 0) begin
            if (failures < MAX_REPORTS)
               $display("response with no request outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            due = outcomes_due.pop_front();
            check_field("read_value", 64'(due.read_value), 64'(rsp_tdata[0 +: DATA_W]));
            check_field("status", 64'(due.status),
                        64'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]));
            check_field("item_count", 64'(due.item_count),
                        64'(rsp_tdata[RSP_COUNT_LSB +: COUNT_W]));
            check_field("is_empty", 64'(due.is_empty), 64'(rsp_tdata[RSP_EMPTY_BIT]));
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      shadow_count  = 0;
      failures      = 0;
      cycles        = 0;
      send_steady   = 1'b0;
      accept_steady = 1'b0;
      repeat (12)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_fill_to_capacity();
      test_random_mix();

      // let the last responses drain, then give the block a few more cycles
      wait_for_idle();
      repeat (TAIL_CYCLES)
         @(posedge clock);
      if (failures == 0 && outcomes_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/core/psl_pkg.sv
rtl/core/psl_cell.sv
rtl/core/psl_read_tree.sv
rtl/core/positional_list_store_unit.sv
bench/positional_list_store_unit_tb.sv
